### hw/rtl/mts_pkg.sv
// Shared constants, codes and control structures of the min-tracking stack.
package mts_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int OP_W        = 2;
    localparam int STAT_W      = 2;

    localparam logic signed [DATA_W-1:0] INT_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_POP  = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic exec;      // apply the accepted transaction to the stack
        logic refill;    // load the top registers from the store read data
        logic load_out;  // capture the result into the output register
    } mts_cmd_t;

    typedef struct packed {
        logic refill_needed;  // a pop now leaves an entry below the top
    } mts_stat_t;

endpackage

### hw/rtl/mts_if.sv
// Valid/ready channel interfaces for the stack's input and result transactions.
interface mts_in_if;
    logic                              valid;
    logic                              ready;
    logic [mts_pkg::OP_W-1:0]          operation;
    logic signed [mts_pkg::DATA_W-1:0] push_value;

    modport source (output valid, output operation, output push_value, input ready);
    modport sink   (input valid, input operation, input push_value, output ready);
endinterface

interface mts_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [mts_pkg::DATA_W-1:0] top_value;
    logic signed [mts_pkg::DATA_W-1:0] min_value;
    logic [mts_pkg::COUNT_W-1:0]       depth_count;
    logic [mts_pkg::STAT_W-1:0]        status;

    modport source (output valid, output top_value, output min_value,
                    output depth_count, output status, input ready);
    modport sink   (input valid, input top_value, input min_value,
                    input depth_count, input status, output ready);
endinterface

### hw/rtl/min_tracking_stack_core.sv
// Top level of the min-tracking stack: sequencer plus datapath behind two channels.
//
//   Channel  Dir  Payload                                        Handshake
//   in_ch    in   operation, push_value                          valid/ready
//   out_ch   out  top_value, min_value, depth_count, status      valid/ready
//
// A push, a peek or a pop that empties or underflows the stack goes from acceptance
// straight to the done state, which loads the result once the output is free; a
// pop that leaves entries passes through the refill state first, because the new top
// comes out of the entry store through its registered read.
// The top entry and the running minimum live in registers, entries below them in
// a store with one write port and one registered read port.
// Reset clears the fill count and the running minimum; the store needs no clearing.
// The next transaction is accepted while an earlier result still waits in the
// output register; a stalled output only holds the block once a second result is due.
module min_tracking_stack_core (
    input  logic      clk,
    input  logic      rst_n,
    mts_in_if.sink    in_ch,
    mts_out_if.source out_ch
);
    import mts_pkg::*;

    mts_cmd_t  cmd;
    mts_stat_t stat;

    // The sequencer decides when the transaction is applied, when the top is
    // refilled from the store, and when the result is copied out.
    mts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_op     (in_ch.operation),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid)
    );

    // The datapath keeps the stack contents and the registered result.
    mts_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .operation   (in_ch.operation),
        .push_value  (in_ch.push_value),
        .stat        (stat),
        .top_value   (out_ch.top_value),
        .min_value   (out_ch.min_value),
        .depth_count (out_ch.depth_count),
        .status      (out_ch.status)
    );

endmodule

### hw/rtl/mts_datapath.sv
// Stack datapath: top registers, entry store, fill count and result register.
module mts_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mts_pkg::mts_cmd_t                 cmd,
    input  logic [mts_pkg::OP_W-1:0]          operation,
    input  logic signed [mts_pkg::DATA_W-1:0] push_value,
    output mts_pkg::mts_stat_t                stat,
    output logic signed [mts_pkg::DATA_W-1:0] top_value,
    output logic signed [mts_pkg::DATA_W-1:0] min_value,
    output logic [mts_pkg::COUNT_W-1:0]       depth_count,
    output logic [mts_pkg::STAT_W-1:0]        status
);
    import mts_pkg::*;

    // Each store entry holds {value, running minimum} of an entry below the top.
    logic [2*DATA_W-1:0]      mem [STACK_DEPTH];
    logic [2*DATA_W-1:0]      rd_data_reg;

    logic [COUNT_W-1:0]       fill_reg, fill_next;
    logic signed [DATA_W-1:0] min_reg, min_next;
    logic signed [DATA_W-1:0] top_reg, top_next;
    logic [STAT_W-1:0]        status_reg, status_next;

    logic signed [DATA_W-1:0] out_top_reg, out_min_reg;
    logic [COUNT_W-1:0]       out_depth_reg;
    logic [STAT_W-1:0]        out_status_reg;

    logic                     is_empty, is_full;
    logic [COUNT_W-1:0]       fill_m1, fill_m2;
    logic [ADDR_W-1:0]        wr_addr, rd_addr;
    logic                     wr_en;

    assign is_empty = (fill_reg == '0);
    assign is_full  = (fill_reg == COUNT_W'(STACK_DEPTH));
    assign fill_m1  = fill_reg - COUNT_W'(1);
    assign fill_m2  = fill_reg - COUNT_W'(2);
    assign wr_addr  = fill_m1[ADDR_W-1:0];
    assign rd_addr  = fill_m2[ADDR_W-1:0];

    assign stat.refill_needed = (fill_reg >= COUNT_W'(2));

    // The old top moves into the store when a push lands on a non-empty stack.
    assign wr_en = cmd.exec && (operation == OP_PUSH) && !is_empty && !is_full;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {top_reg, min_reg};
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        fill_next   = fill_reg;
        min_next    = min_reg;
        top_next    = top_reg;
        status_next = status_reg;
        if (cmd.exec)
        begin
            status_next = STAT_OK;
            case (operation)
                OP_PUSH:
                begin
                    if (is_full)
                    begin
                        status_next = STAT_OVERFLOW;
                    end
                    else
                    begin
                        top_next  = push_value;
                        min_next  = (push_value < min_reg) ? push_value : min_reg;
                        fill_next = fill_reg + COUNT_W'(1);
                    end
                end
                OP_POP:
                begin
                    if (is_empty)
                    begin
                        status_next = STAT_UNDERFLOW;
                    end
                    else
                    begin
                        fill_next = fill_m1;
                        if (fill_reg == COUNT_W'(1))
                        begin
                            top_next = '0;
                            min_next = INT_MAX;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.refill)
        begin
            top_next = rd_data_reg[2*DATA_W-1:DATA_W];
            min_next = rd_data_reg[DATA_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            min_reg  <= INT_MAX;
        end
        else
        begin
            fill_reg <= fill_next;
            min_reg  <= min_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg    <= top_next;
        status_reg <= status_next;
        if (cmd.load_out)
        begin
            out_top_reg    <= is_empty ? '0 : top_reg;
            out_min_reg    <= is_empty ? INT_MAX : min_reg;
            out_depth_reg  <= fill_reg;
            out_status_reg <= status_reg;
        end
    end

    assign top_value   = out_top_reg;
    assign min_value   = out_min_reg;
    assign depth_count = out_depth_reg;
    assign status      = out_status_reg;

endmodule

### hw/rtl/mts_ctrl.sv
// Sequencer of the stack: accepts a transaction, refills the top, hands off the result.
module mts_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [mts_pkg::OP_W-1:0] in_op,
    input  logic                     out_ready,
    input  mts_pkg::mts_stat_t       stat,
    output mts_pkg::mts_cmd_t        cmd,
    output logic                     in_ready,
    output logic                     out_valid
);
    import mts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_REFILL = 3'b010,
        S_DONE   = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd.exec     = 1'b0;
        cmd.refill   = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.exec = 1'b1;
                    if ((in_op == OP_POP) && stat.refill_needed)
                    begin
                        state_next = S_REFILL;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_REFILL:
            begin
                cmd.refill = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.load_out || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hw/rtl/mts_checker.sv
// Port-level checker of the min-tracking stack and its bind to the top level.
module mts_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [mts_pkg::DATA_W-1:0] top_value,
    input logic signed [mts_pkg::DATA_W-1:0] min_value,
    input logic [mts_pkg::COUNT_W-1:0]       depth_count,
    input logic [mts_pkg::STAT_W-1:0]        status
);
    import mts_pkg::*;

    // An empty stack always reports top zero and the empty minimum.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (depth_count == '0)) |-> ((top_value == '0) && (min_value == INT_MAX)))
    else $error("empty stack reported a top or minimum");

    // Overflow only happens on a full stack.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STAT_OVERFLOW)) |-> (depth_count == COUNT_W'(STACK_DEPTH)))
    else $error("overflow flagged on a stack that is not full");

    // Underflow only happens on an empty stack.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STAT_UNDERFLOW)) |-> (depth_count == '0))
    else $error("underflow flagged on a non-empty stack");

    // The minimum never exceeds the top, and depth stays within the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((min_value <= top_value || depth_count == '0)
                       && (depth_count <= COUNT_W'(STACK_DEPTH))))
    else $error("minimum above top or depth out of range");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(top_value)
                                       && $stable(min_value) && $stable(depth_count)
                                       && $stable(status)))
    else $error("stalled result changed");

endmodule

bind min_tracking_stack_core mts_checker u_mts_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .top_value   (out_ch.top_value),
    .min_value   (out_ch.min_value),
    .depth_count (out_ch.depth_count),
    .status      (out_ch.status)
);

### test/min_tracking_stack_core_tb.sv
// Self-checking testbench of the min-tracking stack core: directed and random stack traffic.
module min_tracking_stack_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mts_pkg::*;

    // Operation code three has no name in the package. The block treats it as a peek.
    localparam logic [OP_W-1:0] OP_ALIAS_PEEK = 2'd3;

    // Most negative 32-bit value, the natural partner of INT_MAX.
    localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Snapshot of the stack as one result transaction reports it.
    typedef struct packed {
        logic signed [DATA_W-1:0] top_val;
        logic signed [DATA_W-1:0] min_val;
        logic [COUNT_W-1:0]       depth;
        logic [STAT_W-1:0]        stat;
    } stack_view_t;

    logic clk = 1'b0;
    logic rst_n;

    mts_in_if  in_ch ();
    mts_out_if out_ch ();

    min_tracking_stack_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #2 clk = ~clk;

    // Shadow stack. Each entry keeps its value and the minimum as it stood right
    // after that entry went in, so a pop recovers the minimum from the new top.
    logic signed [DATA_W-1:0] stk_value [STACK_DEPTH];
    logic signed [DATA_W-1:0] stk_min   [STACK_DEPTH];
    int                       stk_fill = 0;
    logic signed [DATA_W-1:0] cur_min  = INT_MAX;

    // Stack snapshots still owed by the block, oldest first.
    stack_view_t snapshot_q [$];

    int mismatch_count = 0;

    // When clear, both the sender and the receiver run without idle cycles.
    bit idle_on = 1'b1;

    // Applies one operation to the shadow stack and returns the snapshot that the
    // block must report for it. A push onto a full stack and a pop from an empty
    // one leave the stack as it was and only raise a status.
    function automatic stack_view_t track_stack_op(input logic [OP_W-1:0] op,
                                                   input logic signed [DATA_W-1:0] value);
        stack_view_t view;
        view.stat = STAT_OK;
        if (op == OP_PUSH)
        begin
            if (stk_fill >= STACK_DEPTH)
                view.stat = STAT_OVERFLOW;
            else
            begin
                if (value < cur_min)
                    cur_min = value;
                stk_value[stk_fill] = value;
                stk_min[stk_fill]   = cur_min;
                stk_fill++;
            end
        end
        else if (op == OP_POP)
        begin
            if (stk_fill == 0)
                view.stat = STAT_UNDERFLOW;
            else
            begin
                stk_fill--;
                cur_min = (stk_fill == 0) ? INT_MAX : stk_min[stk_fill - 1];
            end
        end
        // Peek and code three change nothing.
        if (stk_fill == 0)
        begin
            cur_min      = INT_MAX;
            view.top_val = '0;
        end
        else
            view.top_val = stk_value[stk_fill - 1];
        view.min_val = cur_min;
        view.depth   = COUNT_W'(stk_fill);
        return view;
    endfunction

    // Mix of fully random words, the extremes, and a narrow band around zero so
    // that equal minimums and repeated values show up often.
    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 5))
            0:
            begin
                case ($urandom_range(0, 3))
                    0: v = INT_MIN;
                    1: v = INT_MAX;
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            1, 2: v = $signed(DATA_W'($urandom_range(0, 16))) - 8;
            default: v = $signed($urandom);
        endcase
        return v;
    endfunction

    // Sends one transaction into the stack. Valid stays high from one transaction
    // to the next when no gap is drawn, so it is never dropped and raised in the
    // same time step. The snapshot is recorded at the accepting edge.
    task automatic send_item(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] value);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.operation  <= op;
        in_ch.push_value <= value;
        do
            @(posedge clk);
        while (!in_ch.ready);
        snapshot_q.push_back(track_stack_op(op, value));
    endtask

    // Peek, pop and code three on the empty stack straight after reset. The pops
    // must report underflow with top 0 and the empty minimum.
    task automatic test_empty_stack();
        send_item(OP_PEEK, 32'sd0);
        send_item(OP_POP, pick_value());
        send_item(OP_ALIAS_PEEK, pick_value());
        send_item(OP_POP, INT_MIN);
    endtask

    // Extreme values on a short stack: INT_MAX as the only entry (the minimum
    // equals the empty mark but the stack is not empty), INT_MIN twice so that a
    // pop of one copy keeps the minimum, then a drain past the bottom.
    task automatic test_extreme_values();
        send_item(OP_PUSH, INT_MAX);
        send_item(OP_PEEK, '1);
        send_item(OP_PUSH, INT_MIN);
        send_item(OP_PUSH, 32'sd0);
        send_item(OP_PUSH, -32'sd1);
        send_item(OP_PUSH, INT_MIN);
        send_item(OP_ALIAS_PEEK, INT_MAX);
        repeat (5) send_item(OP_POP, '1);
        send_item(OP_POP, 32'sd0);
        send_item(OP_PUSH, 32'sd1);
        send_item(OP_PUSH, INT_MAX);
        send_item(OP_POP, INT_MIN);
        send_item(OP_POP, 32'sd0);
    endtask

    // Fills the stack to the top with random content, pushes into the full
    // stack, then drains it and pops the empty stack. One round runs without
    // idle cycles so that back-to-back traffic hits both ends.
    task automatic test_full_and_drain();
        for (int round = 0; round < 3; round++)
        begin
            idle_on = (round != 1);
            while (stk_fill < STACK_DEPTH)
                send_item(OP_PUSH, pick_value());
            repeat (3) send_item(OP_PUSH, pick_value());
            send_item(OP_PEEK, pick_value());
            while (stk_fill > 0)
                send_item(OP_POP, pick_value());
            repeat (2) send_item(OP_POP, pick_value());
        end
        idle_on = 1'b1;
    endtask

    // Random walk in phases of 50 transactions. Each phase draws how strongly it
    // leans toward pushes, so the depth wanders over the whole range, and whether
    // the two sides idle at all.
    task automatic test_random_mix();
        int push_pct;
        int pick;
        logic [OP_W-1:0] op;
        for (int phase = 0; phase < 20; phase++)
        begin
            case ($urandom_range(0, 3))
                0: push_pct = 25;
                1: push_pct = 50;
                2: push_pct = 70;
                default: push_pct = 90;
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
            repeat (50)
            begin
                if ($urandom_range(0, 99) < push_pct)
                    op = OP_PUSH;
                else
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 6)
                        op = OP_POP;
                    else if (pick < 9)
                        op = OP_PEEK;
                    else
                        op = OP_ALIAS_PEEK;
                end
                send_item(op, pick_value());
            end
        end
        idle_on = 1'b1;
    endtask

    // Result side: while idle cycles are on, ready drops for a drawn stall before each
    // transaction, then ready stays high until one result has been taken.
    initial
    begin
        int stall;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 6) : 0;
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
        end
    end

    // Every accepted result is held against the oldest snapshot still owed.
    always @(posedge clk)
    begin : result_check
        stack_view_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (snapshot_q.size() == 0)
            begin
                $display("%0t: result with none pending: top %0d min %0d depth %0d status %0d",
                         $time, out_ch.top_value, out_ch.min_value, out_ch.depth_count,
                         out_ch.status);
                mismatch_count++;
            end
            else
            begin
                want = snapshot_q.pop_front();
                if (out_ch.top_value !== want.top_val)
                begin
                    $display("%0t: top_value expected %0d actual %0d",
                             $time, want.top_val, out_ch.top_value);
                    mismatch_count++;
                end
                if (out_ch.min_value !== want.min_val)
                begin
                    $display("%0t: min_value expected %0d actual %0d",
                             $time, want.min_val, out_ch.min_value);
                    mismatch_count++;
                end
                if (out_ch.depth_count !== want.depth)
                begin
                    $display("%0t: depth_count expected %0d actual %0d",
                             $time, want.depth, out_ch.depth_count);
                    mismatch_count++;
                end
                if (out_ch.status !== want.stat)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.stat, out_ch.status);
                    mismatch_count++;
                end
            end
        end
    end

    // Main sequence: reset once, the tests in turn, then let the last results
    // drain and wait on for anything the block should not send.
    initial
    begin
        rst_n            <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.operation  <= OP_PEEK;
        in_ch.push_value <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_stack();
        test_extreme_values();
        test_full_and_drain();
        test_random_mix();

        in_ch.valid <= 1'b0;
        while (snapshot_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: the slowest correct run needs roughly 1450 transactions, and its
    // time stays far below this bound.
    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
